>>> rtl/pica_pkg.sv
// Shared types for the PI controller block: beat payloads, config register
// indexes, and the microcode control word with its program store.
// Used by pica_seq and pi_controller_anti_windup_top.
package pica_pkg;

  localparam int unsigned PC_W = 3;

  localparam logic KIND_RUN   = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] setpoint;
    logic signed [15:0] measured;
  } in_t;

  typedef struct packed {
    logic signed [15:0] drive;
    logic               limited;
  } out_t;

  typedef enum logic [2:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_STEP_PERIOD = 3'd2,
    REG_DRIVE_MIN   = 3'd3,
    REG_DRIVE_MAX   = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_GAIN,
    MUL_INC,
    MUL_PROP
  } mul_sel_t;

  typedef enum logic [1:0] {
    COND_NEVER,
    COND_NO_RUN,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    logic            take;
    mul_sel_t        mul_sel;
    logic            load_gain;
    logic            load_prod;
    logic            load_sum;
    logic            load_cand;
    logic            load_u;
    logic            finish;
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            last;
  } ctrl_t;

  typedef struct packed {
    logic run_beat;
    logic out_busy;
  } status_t;

  localparam logic [PC_W-1:0] PC_WAIT   = 3'd0;
  localparam logic [PC_W-1:0] PC_FINISH = 3'd6;

  // Program: wait for a run beat, form step gain, integral increment, integral sum,
  // candidate clamp with proportional product, unclamped output sum, then finish.
  function automatic ctrl_t pica_rom(input logic [PC_W-1:0] pc);
    ctrl_t c;
    c = '{take: 1'b0, mul_sel: MUL_NONE, load_gain: 1'b0, load_prod: 1'b0,
          load_sum: 1'b0, load_cand: 1'b0, load_u: 1'b0, finish: 1'b0,
          cond: COND_NEVER, target: PC_WAIT, last: 1'b0};
    case (pc)
      3'd0: begin
        c.take   = 1'b1;
        c.cond   = COND_NO_RUN;
        c.target = PC_WAIT;
      end
      3'd1: begin
        c.mul_sel   = MUL_GAIN;
        c.load_gain = 1'b1;
      end
      3'd2: begin
        c.mul_sel   = MUL_INC;
        c.load_prod = 1'b1;
      end
      3'd3: begin
        c.load_sum = 1'b1;
      end
      3'd4: begin
        c.mul_sel   = MUL_PROP;
        c.load_prod = 1'b1;
        c.load_cand = 1'b1;
      end
      3'd5: begin
        c.load_u = 1'b1;
      end
      3'd6: begin
        c.finish = 1'b1;
        c.cond   = COND_OUT_BUSY;
        c.target = PC_FINISH;
        c.last   = 1'b1;
      end
      default: begin
        c.last = 1'b1;
      end
    endcase
    return c;
  endfunction

endpackage

>>> rtl/pica_seq.sv
// Microcode sequencer for the PI controller: step counter, program fetch
// and conditional jumps. Depends on pica_pkg.
module pica_seq (
  input  logic             clk,
  input  logic             rst,
  input  pica_pkg::status_t status,
  output pica_pkg::ctrl_t   ctrl
);
  import pica_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            jump;

  assign ctrl = pica_rom(pc);

  always_comb begin
    case (ctrl.cond)
      COND_NEVER:    jump = 1'b0;
      COND_NO_RUN:   jump = !status.run_beat;
      COND_OUT_BUSY: jump = status.out_busy;
      default:       jump = 1'b0;
    endcase
  end

  always_comb begin
    if (jump) begin
      pc_next = ctrl.target;
    end else if (ctrl.last) begin
      pc_next = PC_WAIT;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

>>> rtl/pi_controller_anti_windup_top.sv
// PI controller with conditional-integration anti-windup.
// A run beat is taken in the wait step and its result is registered in the finish
// step, which holds while the output is busy; no new beat is taken until the program,
// sharing one multiplier over three products, returns to wait. A clear beat stays in wait.
// Reset (synchronous): integral zero, gains zero, limits full 16-bit range,
// no result pending.
module pi_controller_anti_windup_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  pica_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output pica_pkg::out_t   out_data,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import pica_pkg::*;

  // Clamp order: above the upper limit first, then below the lower one.
  function automatic logic signed [31:0] clamp(input logic signed [49:0] v,
                                              input logic signed [15:0] lo16,
                                              input logic signed [15:0] hi16);
    logic signed [49:0] lo;
    logic signed [49:0] hi;
    lo = {{18{lo16[15]}}, lo16, 16'h0000};
    hi = {{18{hi16[15]}}, hi16, 16'h0000};
    if (v > hi) begin
      return hi[31:0];
    end else if (v < lo) begin
      return lo[31:0];
    end
    return v[31:0];
  endfunction

  function automatic logic signed [16:0] setpoint_ext(input logic signed [15:0] v);
    return {v[15], v};
  endfunction

  logic [15:0]        prop_gain;
  logic [23:0]        integ_gain;
  logic [23:0]        step_period;
  logic signed [15:0] drive_min;
  logic signed [15:0] drive_max;

  logic signed [31:0] acc;
  logic signed [16:0] err;
  logic [31:0]        gain;
  logic signed [49:0] prod_r;
  logic signed [49:0] sum;
  logic signed [31:0] cand;
  logic signed [41:0] u;

  logic signed [33:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [58:0] prod;

  ctrl_t   ctrl;
  status_t status;

  logic               cfg_wr;
  logic [2:0]         cfg_idx;
  logic               beat_in;
  logic               fire;
  logic signed [31:0] o;
  logic signed [41:0] o_ext;
  logic signed [41:0] lo_ext;
  logic signed [41:0] hi_ext;
  logic               take_cand;

  pica_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  assign in_ready        = ctrl.take;
  assign beat_in         = in_valid && in_ready;
  assign status.run_beat = in_valid && (in_data.kind == KIND_RUN);
  assign status.out_busy = out_valid && !out_ready;
  assign fire            = ctrl.finish && !status.out_busy;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (cfg_idx)
      REG_PROP_GAIN:   prdata = {16'h0000, prop_gain};
      REG_INTEG_GAIN:  prdata = {8'h00, integ_gain};
      REG_STEP_PERIOD: prdata = {8'h00, step_period};
      REG_DRIVE_MIN:   prdata = {{16{drive_min[15]}}, drive_min};
      REG_DRIVE_MAX:   prdata = {{16{drive_max[15]}}, drive_max};
      default:         prdata = 32'h0000_0000;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain   <= '0;
      integ_gain  <= '0;
      step_period <= '0;
      drive_min   <= 16'sh8000;
      drive_max   <= 16'sh7fff;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PROP_GAIN:   prop_gain   <= pwdata[15:0];
        REG_INTEG_GAIN:  integ_gain  <= pwdata[23:0];
        REG_STEP_PERIOD: step_period <= pwdata[23:0];
        REG_DRIVE_MIN:   drive_min   <= pwdata[15:0];
        REG_DRIVE_MAX:   drive_max   <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // Shared multiplier
  always_comb begin
    case (ctrl.mul_sel)
      MUL_GAIN: begin
        mul_a = {10'b0, integ_gain};
        mul_b = {1'b0, step_period};
      end
      MUL_INC: begin
        mul_a = {2'b00, gain};
        mul_b = {{8{err[16]}}, err};
      end
      MUL_PROP: begin
        mul_a = {18'b0, prop_gain};
        mul_b = {{8{err[16]}}, err};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Final clamp and the anti-windup decision
  assign o      = clamp({{8{u[41]}}, u}, drive_min, drive_max);
  assign o_ext  = {{10{o[31]}}, o};
  assign lo_ext = {{10{drive_min[15]}}, drive_min, 16'h0000};
  assign hi_ext = {{10{drive_max[15]}}, drive_max, 16'h0000};
  assign take_cand = (u == o_ext)
                  || ((u > hi_ext) && err[16])
                  || ((u < lo_ext) && !err[16] && (err != '0));

  // Datapath registers
  always_ff @(posedge clk) begin
    if (beat_in) begin
      err <= {setpoint_ext(in_data.setpoint)} - {setpoint_ext(in_data.measured)};
    end
    if (ctrl.load_gain) begin
      gain <= prod[47:16];
    end
    if (ctrl.load_prod) begin
      prod_r <= prod[49:0];
    end
    if (ctrl.load_sum) begin
      sum <= {{18{acc[31]}}, acc} + prod_r;
    end
    if (ctrl.load_cand) begin
      cand <= clamp(sum, drive_min, drive_max);
    end
    if (ctrl.load_u) begin
      u <= {prod_r[33:0], 8'h00} + {{10{cand[31]}}, cand};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (beat_in && (in_data.kind == KIND_CLEAR)) begin
      acc <= '0;
    end else if (fire && take_cand) begin
      acc <= cand;
    end
  end

  // Output register: hold until the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data.drive   <= o[31:16];
      out_data.limited <= (u != o_ext);
    end
  end

`ifndef ASSERT_OFF
  a_run_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (in_data.kind == KIND_RUN)) |=> !in_ready)
    else $error("input taken while a run step is in progress");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (in_data.kind == KIND_CLEAR)) |=> (acc == '0))
    else $error("clear beat did not zero the integral");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctrl.finish))
    else $error("result appeared outside the finish step");

  a_drive_in_limits: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid) && ($past(drive_min) <= $past(drive_max))) |->
      ((out_data.drive >= $past(drive_min)) && (out_data.drive <= $past(drive_max))))
    else $error("drive outside the configured limits");
`endif

endmodule
